// ===== hdl/edfq_pkg.sv =====
// edfq_pkg: shared types and constants of the EDF ready queue scheduler.
// Used by the cell, the channel interfaces and the top level.
`timescale 1ns / 1ps

package edfq_pkg;

	// Widths fixed by the item formats
	localparam int DL_W        = 64;
	localparam int RES_W       = 8;
	localparam int MAX_THREADS_DEF = 128;

	// Item operation codes
	localparam logic OP_CREATE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Command broadcast to every queue cell
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH,
		CMD_POP,
		CMD_REPLACE
	} cell_cmd_t;

	// Control bundle from the top level to the cell row
	typedef struct packed {
		cell_cmd_t         cmd;
		logic [DL_W-1:0]   dl;
	} cell_ctl_t;

endpackage

// ===== hdl/edfq_in_if.sv =====
// edfq_in_if: input channel of the EDF scheduler (valid/ready plus item fields).
// Depends on edfq_pkg for field widths.
`timescale 1ns / 1ps

interface edfq_in_if
	import edfq_pkg::*;
;
	logic            valid;
	logic            ready;
	logic            op;
	logic [DL_W-1:0] deadline;

	modport source (output valid, output op, output deadline, input ready);
	modport sink   (input valid, input op, input deadline, output ready);
endinterface

// ===== hdl/edfq_out_if.sv =====
// edfq_out_if: result channel of the EDF scheduler (valid/ready plus result fields).
// Depends on edfq_pkg for field widths.
`timescale 1ns / 1ps

interface edfq_out_if
	import edfq_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [RES_W-1:0] result_tid;
	logic [RES_W-1:0] preempted_tid;
	logic             dispatched;

	modport source (output valid, output result_tid, output preempted_tid,
		output dispatched, input ready);
	modport sink   (input valid, input result_tid, input preempted_tid,
		input dispatched, output ready);
endinterface

// ===== hdl/edfq_cell.sv =====
// edfq_cell: one slot of the sorted ready queue, talks to its two neighbors.
// Depends on edfq_pkg for the command type and deadline width.
`timescale 1ns / 1ps

module edfq_cell
	import edfq_pkg::*;
#(
	parameter int TID_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [TID_W-1:0] new_tid,
	input  logic             at_head,
	// neighbor toward the head
	input  logic             prev_valid,
	input  logic [DL_W-1:0]  prev_dl,
	input  logic [TID_W-1:0] prev_tid,
	input  logic             prev_keep,
	// neighbor toward the tail
	input  logic             next_valid,
	input  logic [DL_W-1:0]  next_dl,
	input  logic [TID_W-1:0] next_tid,
	input  logic             next_keep,
	// own contents
	output logic             valid,
	output logic [DL_W-1:0]  dl,
	output logic [TID_W-1:0] tid,
	output logic             keep
);

	logic             valid_q;
	logic [DL_W-1:0]  dl_q;
	logic [TID_W-1:0] tid_q;

	typedef enum logic [1:0] {
		SRC_OWN,
		SRC_NEW,
		SRC_PREV,
		SRC_NEXT
	} src_t;

	src_t src;

	// Entry stays ahead of the new deadline (equal deadlines keep their place)
	assign keep = valid_q && (dl_q <= ctl.dl);

	// Pick where this slot loads from
	always_comb begin
		src = SRC_OWN;
		case (ctl.cmd)
			CMD_PUSH: begin
				if (keep)
					src = SRC_OWN;
				else if (prev_keep || at_head)
					src = SRC_NEW;
				else
					src = SRC_PREV;
			end
			CMD_POP: src = SRC_NEXT;
			CMD_REPLACE: begin
				// head leaves while the new entry drops into place
				if (next_keep)
					src = SRC_NEXT;
				else if (keep || at_head)
					src = SRC_NEW;
				else
					src = SRC_OWN;
			end
			default: src = SRC_OWN;
		endcase
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (src)
				SRC_NEW:  valid_q <= 1'b1;
				SRC_PREV: valid_q <= prev_valid;
				SRC_NEXT: valid_q <= next_valid;
				default:  valid_q <= valid_q;
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		case (src)
			SRC_NEW: begin
				dl_q  <= ctl.dl;
				tid_q <= new_tid;
			end
			SRC_PREV: begin
				dl_q  <= prev_dl;
				tid_q <= prev_tid;
			end
			SRC_NEXT: begin
				dl_q  <= next_dl;
				tid_q <= next_tid;
			end
			default: begin
				dl_q  <= dl_q;
				tid_q <= tid_q;
			end
		endcase
	end

	assign valid = valid_q;
	assign dl    = dl_q;
	assign tid   = tid_q;

endmodule

// ===== hdl/edf_ready_queue_scheduler.sv =====
// edf_ready_queue_scheduler: EDF ready queue built as a row of sorted cells.
// Depends on edfq_pkg, edfq_in_if, edfq_out_if and edfq_cell.
//
//   channel | dir | fields                                    | handshake
//   in_ch   | in  | op, deadline                              | valid/ready
//   out_ch  | out | result_tid, preempted_tid, dispatched     | valid/ready
//
// Each item is handled in two steps: the beat is captured, then every cell
// compares its deadline in parallel and the row shifts at most once (insert,
// pop, or pop plus re-insert of a preempted thread); no new beat is taken meanwhile.
// Reset clears the cell valid bits, the id counter and the running slot.
// A result waiting in the output register does not stop the next beat from
// being captured; execution waits only while that register is still full.
`timescale 1ns / 1ps

module edf_ready_queue_scheduler
	import edfq_pkg::*;
#(
	parameter int MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	edfq_in_if.sink      in_ch,
	edfq_out_if.source   out_ch
);

	// Id width, never narrower than the result fields
	localparam int TID_W = ($clog2(MAX_THREADS + 1) > RES_W) ?
		$clog2(MAX_THREADS + 1) : RES_W;

	// Captured item
	logic             busy_q;
	logic             op_q;
	logic [DL_W-1:0]  dl_q;

	// Scheduler state
	logic [TID_W-1:0] created_q;
	logic [TID_W-1:0] run_id_q;
	logic [DL_W-1:0]  run_dl_q;

	// Output register
	logic             out_valid_q;
	logic [RES_W-1:0] res_tid_q;
	logic [RES_W-1:0] pre_tid_q;
	logic             disp_q;

	// Cell row wiring
	logic             cell_valid [MAX_THREADS];
	logic [DL_W-1:0]  cell_dl    [MAX_THREADS];
	logic [TID_W-1:0] cell_tid   [MAX_THREADS];
	logic             cell_keep  [MAX_THREADS];

	cell_ctl_t        ctl;
	logic [TID_W-1:0] new_tid;

	logic             exec_fire;
	logic             pool_full;
	logic             take_head;
	logic [TID_W-1:0] res_tid;
	logic [TID_W-1:0] pre_tid;
	logic             disp;

	assign in_ch.ready = !busy_q;
	assign exec_fire   = busy_q && (!out_valid_q || out_ch.ready);
	assign pool_full   = (created_q == TID_W'(MAX_THREADS));

	// Decide the operation for this item
	always_comb begin
		ctl.cmd   = CMD_HOLD;
		ctl.dl    = dl_q;
		new_tid   = created_q + 1'b1;
		take_head = 1'b0;
		res_tid   = '0;
		pre_tid   = '0;
		disp      = 1'b0;
		case (op_q)
			OP_CREATE: begin
				if (!pool_full) begin
					ctl.cmd = CMD_PUSH;
					res_tid = created_q + 1'b1;
				end
			end
			OP_TICK: begin
				res_tid = run_id_q;
				if (cell_valid[0]) begin
					if (run_id_q != '0 && cell_dl[0] < run_dl_q) begin
						take_head = 1'b1;
						ctl.cmd   = CMD_REPLACE;
						ctl.dl    = run_dl_q;
						new_tid   = run_id_q;
						pre_tid   = run_id_q;
					end else if (run_id_q == '0) begin
						take_head = 1'b1;
						ctl.cmd   = CMD_POP;
					end
					if (take_head) begin
						res_tid = cell_tid[0];
						disp    = 1'b1;
					end
				end
			end
			default: ctl.cmd = CMD_HOLD;
		endcase
		if (!exec_fire)
			ctl.cmd = CMD_HOLD;
	end

	// Row of queue cells, head at index 0
	for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
		logic             p_valid;
		logic [DL_W-1:0]  p_dl;
		logic [TID_W-1:0] p_tid;
		logic             p_keep;
		logic             n_valid;
		logic [DL_W-1:0]  n_dl;
		logic [TID_W-1:0] n_tid;
		logic             n_keep;

		if (i == 0) begin : g_head
			assign p_valid = 1'b0;
			assign p_dl    = '0;
			assign p_tid   = '0;
			assign p_keep  = 1'b0;
		end else begin : g_mid
			assign p_valid = cell_valid[i-1];
			assign p_dl    = cell_dl[i-1];
			assign p_tid   = cell_tid[i-1];
			assign p_keep  = cell_keep[i-1];
		end

		if (i == MAX_THREADS - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_dl    = '0;
			assign n_tid   = '0;
			assign n_keep  = 1'b0;
		end else begin : g_body
			assign n_valid = cell_valid[i+1];
			assign n_dl    = cell_dl[i+1];
			assign n_tid   = cell_tid[i+1];
			assign n_keep  = cell_keep[i+1];
		end

		edfq_cell #(
			.TID_W(TID_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_tid    (new_tid),
			.at_head    (i == 0),
			.prev_valid (p_valid),
			.prev_dl    (p_dl),
			.prev_tid   (p_tid),
			.prev_keep  (p_keep),
			.next_valid (n_valid),
			.next_dl    (n_dl),
			.next_tid   (n_tid),
			.next_keep  (n_keep),
			.valid      (cell_valid[i]),
			.dl         (cell_dl[i]),
			.tid        (cell_tid[i]),
			.keep       (cell_keep[i])
		);
	end

	// Capture an input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			busy_q <= 1'b1;
		end else if (exec_fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			op_q <= in_ch.op;
			dl_q <= in_ch.deadline;
		end
	end

	// Advance the id counter and the running slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= '0;
			run_id_q  <= '0;
		end else if (exec_fire) begin
			if (op_q == OP_CREATE && !pool_full)
				created_q <= created_q + 1'b1;
			if (take_head)
				run_id_q <= cell_tid[0];
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire && take_head)
			run_dl_q <= cell_dl[0];
	end

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			res_tid_q <= res_tid[RES_W-1:0];
			pre_tid_q <= pre_tid[RES_W-1:0];
			disp_q    <= disp;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.result_tid    = res_tid_q;
	assign out_ch.preempted_tid = pre_tid_q;
	assign out_ch.dispatched    = disp_q;

endmodule

// ===== tb/tb_edf_ready_queue_scheduler.sv =====
// tb_edf_ready_queue_scheduler: self-checking bench for the EDF ready queue scheduler.
// Predicts create and tick outcomes and compares every result beat under random idling and stalls.
// Depends on edfq_pkg, edfq_in_if, edfq_out_if and edf_ready_queue_scheduler.
`timescale 1ns / 1ps

module tb_edf_ready_queue_scheduler;
	import edfq_pkg::*;

	localparam int N_THREADS = MAX_THREADS_DEF;
	localparam int ITEMS_PER_PHASE = 475;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [RES_W-1:0] tid;
		logic [RES_W-1:0] preempted;
		logic             dispatched;
	} sched_outcome_t;

	// Scheduler predictor plus the store of outcomes still owed by the block
	class sched_scoreboard;
		logic [DL_W-1:0] ready_dl[$];
		int unsigned     ready_id[$];
		int unsigned     created = 0;
		int unsigned     run_id = 0;
		logic [DL_W-1:0] run_dl = '0;
		sched_outcome_t  owed[$];
		int              errors = 0;

		function void report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endfunction

		// Insert after any equal deadline; a full queue drops the insert
		function void enqueue(int unsigned id, logic [DL_W-1:0] dl);
			int pos;
			if (ready_dl.size() >= N_THREADS)
				return;
			pos = 0;
			while (pos < ready_dl.size() && ready_dl[pos] <= dl)
				pos++;
			ready_dl.insert(pos, dl);
			ready_id.insert(pos, id);
		endfunction

		function void note_item(logic op, logic [DL_W-1:0] dl);
			sched_outcome_t o;
			o = '0;
			if (op == OP_CREATE) begin
				if (created < N_THREADS) begin
					created++;
					o.tid = created[RES_W-1:0];
					enqueue(created, dl);
				end
			end else begin
				if (ready_dl.size() != 0) begin
					// preempt only on a strictly earlier head
					if (run_id != 0 && ready_dl[0] < run_dl) begin
						o.preempted = run_id[RES_W-1:0];
						enqueue(run_id, run_dl);
						run_id = 0;
					end
					if (run_id == 0) begin
						run_id = ready_id.pop_front();
						run_dl = ready_dl.pop_front();
						o.dispatched = 1'b1;
					end
				end
				o.tid = run_id[RES_W-1:0];
			end
			owed.push_back(o);
		endfunction

		function void check_outcome(logic [RES_W-1:0] tid, logic [RES_W-1:0] preempted,
			logic dispatched);
			sched_outcome_t o;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result tid=%0d", tid));
				return;
			end
			o = owed.pop_front();
			if (tid !== o.tid)
				report($sformatf("result_tid %0d, want %0d", tid, o.tid));
			if (preempted !== o.preempted)
				report($sformatf("preempted_tid %0d, want %0d", preempted, o.preempted));
			if (dispatched !== o.dispatched)
				report($sformatf("dispatched %0b, want %0b", dispatched, o.dispatched));
		endfunction
	endclass

	logic clk;
	logic arst_n;

	edfq_in_if  in_ch();
	edfq_out_if out_ch();

	edf_ready_queue_scheduler #(
		.MAX_THREADS(N_THREADS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	sched_scoreboard sb = new();

	int idle_pct = 0;
	int stall_pct = 0;
	bit start_hold = 0;
	int hold_left = 0;

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Check result beats and drive ready; a requested hold-off is counted here
	always @(posedge clk) begin
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
			sb.check_outcome(out_ch.result_tid, out_ch.preempted_tid, out_ch.dispatched);
		if (start_hold) begin
			start_hold = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Offer one beat after a random gap; valid stays high for the next call
	task automatic send_item(input logic op, input logic [DL_W-1:0] dl);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.op       <= op;
		in_ch.deadline <= dl;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		sb.note_item(op, dl);
	endtask

	// Mix of ties, small spreads, extremes and full-range deadlines
	function automatic logic [DL_W-1:0] pick_deadline();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3, 4: return DL_W'($urandom_range(15));
			5, 6: return DL_W'($urandom_range(2000));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		in_ch.valid    = 1'b0;
		in_ch.op       = OP_CREATE;
		in_ch.deadline = '0;
		out_ch.ready   = 1'b0;
		arst_n         = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty tick, extremes, equal deadlines, preemption
		send_item(OP_TICK, '1);
		send_item(OP_CREATE, '1);
		send_item(OP_TICK, '0);
		send_item(OP_TICK, '0);
		send_item(OP_CREATE, '1);
		send_item(OP_TICK, {$urandom, $urandom});
		send_item(OP_CREATE, 64'h8000_0000_0000_0000);
		send_item(OP_TICK, '0);
		send_item(OP_CREATE, '0);
		send_item(OP_CREATE, '0);
		send_item(OP_TICK, '1);
		send_item(OP_TICK, '1);
		send_item(OP_CREATE, 64'h5555_5555_5555_5555);
		send_item(OP_CREATE, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_CREATE, 64'd1);
		send_item(OP_TICK, '0);
		send_item(OP_TICK, '0);

		// Random phases: none (plus a ready hold-off), sender idle, receiver stall, both light
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  start_hold = 1; end
				1: begin idle_pct = 66; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 66; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 12)
					send_item(OP_CREATE, pick_deadline());
				else
					send_item(OP_TICK, {$urandom, $urandom});
			end
		end
		in_ch.valid <= 1'b0;

		// Drain, then watch for stray results
		for (int w = 0; w < 5000 && sb.owed.size() != 0; w++)
			@(posedge clk);
		if (sb.owed.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.owed.size()));
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
